@@ sv/p2rgb_pkg.sv @@
// Shared types and constants for the pixel to 8-bit RGB converter.
// No dependencies.
package p2rgb_pkg;

   localparam int SAMPLE_W = 16;
   localparam int CH_W     = 8;
   localparam int NUM_CH   = 3;

   localparam logic [2:0] FMT_RGB   = 3'd0;
   localparam logic [2:0] FMT_RGBA  = 3'd1;
   localparam logic [2:0] FMT_GREY  = 3'd2;
   localparam logic [2:0] FMT_GREYA = 3'd3;
   localparam logic [2:0] FMT_CMYK  = 3'd4;

   localparam logic [1:0] REG_FORMAT = 2'd0;
   localparam logic [1:0] REG_BG_RED = 2'd1;
   localparam logic [1:0] REG_BG_GRN = 2'd2;
   localparam logic [1:0] REG_BG_BLU = 2'd3;

   localparam logic [1:0] OP_PASS  = 2'd0;
   localparam logic [1:0] OP_BLEND = 2'd1;
   localparam logic [1:0] OP_SUB   = 2'd2;

   localparam logic [CH_W-1:0] FULL_SCALE = 8'd255;

   // stage 1 -> stage 2
   typedef struct packed {
      logic [1:0]                   op;
      logic [CH_W-1:0]              weight;  // alpha weight or black
      logic [NUM_CH-1:0][CH_W-1:0]  col;     // colour, ink or final value
      logic [NUM_CH-1:0][CH_W-1:0]  bg;
   } p2rgb_unp_type;

   // stage 2 -> stage 3
   typedef struct packed {
      logic                                   is_div;
      logic [NUM_CH-1:0][2*CH_W-1:0]          val;
   } p2rgb_mix_type;

endpackage

@@ sv/p2rgb_unpack.sv @@
// Stage 1: takes the top byte of each sample and decodes the pixel format.
// Depends on p2rgb_pkg.
module p2rgb_unpack
   import p2rgb_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [4*SAMPLE_W-1:0]             in_data,
   input  logic [2:0]                        pixel_format,
   input  logic [NUM_CH-1:0][CH_W-1:0]       background,
   output logic                              out_valid,
   input  logic                              out_ready,
   output p2rgb_unp_type                     out_data
);

   logic            valid_ff, valid_in;
   p2rgb_unp_type   data_ff, data_in;
   logic [CH_W-1:0] s0, s1, s2, s3, grey;

   assign s0   = in_data[SAMPLE_BITS-1 -: CH_W];
   assign s1   = in_data[SAMPLE_W+SAMPLE_BITS-1 -: CH_W];
   assign s2   = in_data[2*SAMPLE_W+SAMPLE_BITS-1 -: CH_W];
   assign s3   = in_data[3*SAMPLE_W+SAMPLE_BITS-1 -: CH_W];
   assign grey = ~s0;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      data_in        = data_ff;
      if (in_valid && in_ready) begin
         data_in.bg     = background;
         data_in.op     = OP_PASS;
         data_in.weight = '0;
         data_in.col    = '0;
         case (pixel_format)
            FMT_RGB: begin
               data_in.col = {s2, s1, s0};
            end
            FMT_RGBA: begin
               data_in.op     = OP_BLEND;
               data_in.weight = FULL_SCALE - s3;
               data_in.col    = {s2, s1, s0};
            end
            FMT_GREY: begin
               data_in.col = {grey, grey, grey};
            end
            FMT_GREYA: begin
               data_in.op     = OP_BLEND;
               data_in.weight = FULL_SCALE - s1;
               data_in.col    = {grey, grey, grey};
            end
            FMT_CMYK: begin
               data_in.op     = OP_SUB;
               data_in.weight = s3;
               data_in.col    = {s2, s1, s0};
            end
            default: begin
               data_in.op = OP_PASS;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ sv/p2rgb_mix.sv @@
// Stage 2: blend products, ink subtraction with clamp, or pass-through.
// Depends on p2rgb_pkg.
module p2rgb_mix
   import p2rgb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  p2rgb_unp_type   in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output p2rgb_mix_type   out_data
);

   logic            valid_ff, valid_in;
   p2rgb_mix_type   data_ff, data_in;
   logic [CH_W-1:0] inv_w;

   assign inv_w    = FULL_SCALE - in_data.weight;
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      logic [CH_W:0] sum;
      sum     = '0;
      data_in = data_ff;
      if (in_valid && in_ready) begin
         data_in.is_div = (in_data.op == OP_BLEND);
         for (int c = 0; c < NUM_CH; c++) begin
            case (in_data.op)
               OP_BLEND: begin
                  data_in.val[c] = {{CH_W{1'b0}}, in_data.col[c]}
                                   * {{CH_W{1'b0}}, in_data.weight}
                                 + {{CH_W{1'b0}}, in_data.bg[c]}
                                   * {{CH_W{1'b0}}, inv_w};
               end
               OP_SUB: begin
                  sum = {1'b0, in_data.col[c]} + {1'b0, in_data.weight};
                  if (sum >= {1'b0, FULL_SCALE}) begin
                     data_in.val[c] = '0;
                  end else begin
                     data_in.val[c] = {{CH_W{1'b0}}, FULL_SCALE - sum[CH_W-1:0]};
                  end
               end
               default: begin
                  data_in.val[c] = {{CH_W{1'b0}}, in_data.col[c]};
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   a_pass_narrow: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !data_ff.is_div |->
         data_ff.val[0][2*CH_W-1:CH_W] == '0 && data_ff.val[1][2*CH_W-1:CH_W] == '0
         && data_ff.val[2][2*CH_W-1:CH_W] == '0)
      else $error("pass-through word has high bits set");

   a_blend_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff && data_ff.is_div |->
         data_ff.val[0] <= 16'd65025 && data_ff.val[1] <= 16'd65025
         && data_ff.val[2] <= 16'd65025)
      else $error("blend sum above full scale squared");

endmodule

@@ sv/p2rgb_div.sv @@
// Stage 3: divide blend sums by 255 and hold the output word.
// Depends on p2rgb_pkg.
module p2rgb_div
   import p2rgb_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  p2rgb_mix_type                 in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [NUM_CH-1:0][CH_W-1:0]   out_data
);

   logic                         valid_ff, valid_in;
   logic [NUM_CH-1:0][CH_W-1:0]  data_ff, data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // x / 255 == (x + (x >> 8) + 1) >> 8 for x up to 255 * 255
   always_comb begin
      logic [2*CH_W:0] t;
      t       = '0;
      data_in = data_ff;
      if (in_valid && in_ready) begin
         for (int c = 0; c < NUM_CH; c++) begin
            t = {1'b0, in_data.val[c]} + {{(CH_W+1){1'b0}}, in_data.val[c][2*CH_W-1:CH_W]}
              + {{(2*CH_W){1'b0}}, 1'b1};
            data_in[c] = in_data.is_div ? t[2*CH_W-1:CH_W] : in_data.val[c][CH_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   a_load: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff)
      else $error("accepted word not held");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(data_ff))
      else $error("stalled output word changed");

endmodule

@@ sv/pixel_to_rgb8_with_background_top.sv @@
// Top level of the pixel to 8-bit RGB converter with background blending.
// Depends on p2rgb_pkg, p2rgb_unpack, p2rgb_mix, p2rgb_div.
//
//   port group | dir | word
//   req_       | in  | four samples, 16 bits each
//   rsp_       | out | red, green, blue, 8 bits each
//   csr_       | in  | index 0 format, 1..3 background red/green/blue
//
// Three register stages: unpack/decode, multiply/subtract, divide by 255.
// One pixel per clock while rsp_ does not stall; an accepted req word passes
// through the unpack, mix and divide registers before it shows on rsp_.
// Each stage takes a word when empty or when its word moves on, so a stall
// on rsp_ fills the pipeline and then drops req_tready.
// Synchronous reset empties the pipeline and sets format rgb, background white.
module pixel_to_rgb8_with_background_top
   import p2rgb_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [63:0]          req_tdata,   // sample_first, _second, _third, _fourth
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,   // red_out, green_out, blue_out
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [7:0]           csr_wdata
);

   logic [2:0]                   format_ff;
   logic [NUM_CH-1:0][CH_W-1:0]  bg_ff;
   logic                         v1, r1, v2, r2;
   p2rgb_unp_type                d1;
   p2rgb_mix_type                d2;
   logic [NUM_CH-1:0][CH_W-1:0]  rgb;

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FMT_RGB;
         bg_ff     <= {NUM_CH{FULL_SCALE}};
      end else if (csr_we) begin
         case (csr_index)
            REG_FORMAT: format_ff <= csr_wdata[2:0];
            REG_BG_RED: bg_ff[0]  <= csr_wdata;
            REG_BG_GRN: bg_ff[1]  <= csr_wdata;
            REG_BG_BLU: bg_ff[2]  <= csr_wdata;
            default:    format_ff <= format_ff;
         endcase
      end
   end

   p2rgb_unpack #(.SAMPLE_BITS(SAMPLE_BITS)) u_unpack (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_data      (req_tdata),
      .pixel_format (format_ff),
      .background   (bg_ff),
      .out_valid    (v1),
      .out_ready    (r1),
      .out_data     (d1)
   );

   p2rgb_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v1),
      .in_ready  (r1),
      .in_data   (d1),
      .out_valid (v2),
      .out_ready (r2),
      .out_data  (d2)
   );

   p2rgb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2),
      .in_ready  (r2),
      .in_data   (d2),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rgb)
   );

   assign rsp_tdata = rgb;

endmodule

@@ bench/pixel_to_rgb8_with_background_top_test.sv @@
// Self-checking bench for pixel_to_rgb8_with_background_top: directed table, then random phases.
// Each phase sets the registers while idle; random gaps on req_ and stalls on rsp_.
// Depends on p2rgb_pkg and the RTL top level only.
module pixel_to_rgb8_with_background_top_test;
   import p2rgb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] FMT_RSVD5 = 3'd5;
   localparam logic [2:0] FMT_RSVD6 = 3'd6;
   localparam logic [2:0] FMT_RSVD7 = 3'd7;
   localparam int FULL = 255;
   localparam int PHASES = 25;
   localparam int PIXELS_PER_PHASE = 50;
   localparam int MAX_REPORTS = 20;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_t;

   typedef struct packed {
      logic [7:0]  fmt_word;
      logic [7:0]  bg_r;
      logic [7:0]  bg_g;
      logic [7:0]  bg_b;
      logic [15:0] s1;
      logic [15:0] s2;
      logic [15:0] s3;
      logic [15:0] s4;
      logic        typed;
      rgb_t        want;
   } dir_row_t;

   // typed rows carry the result read straight off the conversion rules
   localparam dir_row_t DIRECTED [0:19] = '{
      '{{5'd0, FMT_RGB},   8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'h0000, 16'h80FF, 16'h1234,
        1'b1, '{8'hFF, 8'h00, 8'h80}},
      '{{5'd0, FMT_RGB},   8'hFF, 8'hFF, 8'hFF, 16'h00FF, 16'hFF00, 16'h7F80, 16'hFFFF,
        1'b1, '{8'h00, 8'hFF, 8'h7F}},
      '{{5'd0, FMT_RGBA},  8'h10, 8'h20, 8'h30, 16'hAAAA, 16'hBBBB, 16'hCCCC, 16'hFF00,
        1'b1, '{8'h10, 8'h20, 8'h30}},
      '{{5'd0, FMT_RGBA},  8'h10, 8'h20, 8'h30, 16'h1234, 16'h5678, 16'h9ABC, 16'h00FF,
        1'b1, '{8'h12, 8'h56, 8'h9A}},
      '{{5'd0, FMT_RGBA},  8'h00, 8'h00, 8'h00, 16'hFFFF, 16'h8000, 16'h0000, 16'h8000,
        1'b0, '{8'h00, 8'h00, 8'h00}},
      '{{5'd0, FMT_RGBA},  8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'h8000, 16'h0000, 16'h7F00,
        1'b0, '{8'h00, 8'h00, 8'h00}},
      '{{5'd0, FMT_GREY},  8'hFF, 8'hFF, 8'hFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        1'b1, '{8'hFF, 8'hFF, 8'hFF}},
      '{{5'd0, FMT_GREY},  8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
        1'b1, '{8'h00, 8'h00, 8'h00}},
      '{{5'd0, FMT_GREY},  8'hFF, 8'hFF, 8'hFF, 16'h0100, 16'h1234, 16'h5678, 16'h9ABC,
        1'b1, '{8'hFE, 8'hFE, 8'hFE}},
      '{{5'd0, FMT_GREYA}, 8'h00, 8'h80, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
        1'b1, '{8'hFF, 8'hFF, 8'hFF}},
      '{{5'd0, FMT_GREYA}, 8'h00, 8'h80, 8'hFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000,
        1'b1, '{8'h00, 8'h80, 8'hFF}},
      '{{5'd0, FMT_GREYA}, 8'h00, 8'h80, 8'hFF, 16'h3000, 16'h8000, 16'hFFFF, 16'h0000,
        1'b0, '{8'h00, 8'h00, 8'h00}},
      '{{5'd0, FMT_CMYK},  8'h00, 8'h80, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        1'b1, '{8'hFF, 8'hFF, 8'hFF}},
      '{{5'd0, FMT_CMYK},  8'h00, 8'h80, 8'hFF, 16'h0000, 16'h1234, 16'hFFFF, 16'hFF00,
        1'b1, '{8'h00, 8'h00, 8'h00}},
      '{{5'd0, FMT_CMYK},  8'h00, 8'h80, 8'hFF, 16'h8000, 16'h7F00, 16'h0000, 16'h7F00,
        1'b1, '{8'h00, 8'h01, 8'h80}},
      '{{5'd0, FMT_CMYK},  8'h00, 8'h80, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF,
        1'b1, '{8'h00, 8'h00, 8'h00}},
      '{{5'd0, FMT_RSVD5}, 8'h00, 8'h80, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
        1'b1, '{8'h00, 8'h00, 8'h00}},
      '{{5'd0, FMT_RSVD6}, 8'h00, 8'h80, 8'hFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
        1'b1, '{8'h00, 8'h00, 8'h00}},
      '{{5'h1F, FMT_RSVD7}, 8'h00, 8'h80, 8'hFF, 16'hFFFF, 16'h1234, 16'h5678, 16'h0000,
        1'b1, '{8'h00, 8'h00, 8'h00}},
      '{{5'h1F, FMT_RGB},  8'h00, 8'h80, 8'hFF, 16'hABCD, 16'hEF01, 16'h2345, 16'h6789,
        1'b1, '{8'hAB, 8'hEF, 8'h23}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;    // sample_first, sample_second, sample_third, sample_fourth
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // red_out, green_out, blue_out
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   // register shadow, reset values
   logic [7:0]  csr_word [4] = '{8'h00, 8'hFF, 8'hFF, 8'hFF};
   rgb_t        pending_pixels [$];
   int          req_gap_max = 3;
   int          rsp_stall_max = 3;
   int          errors = 0;
   int          pixels_sent = 0;
   int          pixels_checked = 0;
   int          settings = 0;
   int          fmt_hits [8] = '{default: 0};

   pixel_to_rgb8_with_background_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #400_000;
      $display("%0t: timeout, %0d pixels still pending", $time, pending_pixels.size());
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [7:0] blend8(input logic [7:0] colour, input logic [7:0] bg,
                                         input logic [7:0] w);
      int unsigned acc;
      acc = colour * w + bg * (FULL - w);
      return 8'(acc / FULL);
   endfunction

   function automatic logic [7:0] ink_to_channel(input logic [7:0] ink, input logic [7:0] k);
      int unsigned sum;
      sum = 32'(ink) + 32'(k);
      return (sum >= FULL) ? 8'd0 : 8'(FULL - sum);
   endfunction

   function automatic rgb_t convert_pixel(input logic [63:0] px);
      logic [7:0]  b1, b2, b3, b4, grey, w;
      logic [15:0] inv;
      rgb_t        o;
      b1 = px[15:8];
      b2 = px[31:24];
      b3 = px[47:40];
      b4 = px[63:56];
      inv = 16'hFFFF - px[15:0];
      grey = inv[15:8];
      o = '{8'd0, 8'd0, 8'd0};
      case (csr_word[REG_FORMAT][2:0])
         FMT_RGB: begin
            o = '{b1, b2, b3};
         end
         FMT_RGBA: begin
            w = 8'(FULL) - b4;
            o = '{blend8(b1, csr_word[REG_BG_RED], w), blend8(b2, csr_word[REG_BG_GRN], w),
                  blend8(b3, csr_word[REG_BG_BLU], w)};
         end
         FMT_GREY: begin
            o = '{grey, grey, grey};
         end
         FMT_GREYA: begin
            w = 8'(FULL) - b2;
            o = '{blend8(grey, csr_word[REG_BG_RED], w), blend8(grey, csr_word[REG_BG_GRN], w),
                  blend8(grey, csr_word[REG_BG_BLU], w)};
         end
         FMT_CMYK: begin
            o = '{ink_to_channel(b1, b4), ink_to_channel(b2, b4), ink_to_channel(b3, b4)};
         end
         default: begin
            o = '{8'd0, 8'd0, 8'd0};
         end
      endcase
      return o;
   endfunction

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_background();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_pixel(input logic [63:0] px, input logic typed, input rgb_t want);
      int gap;
      gap = (req_gap_max > 0) ? $urandom_range(0, req_gap_max) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      do @(posedge clock); while (!req_tready);
      pending_pixels.push_back(typed ? want : convert_pixel(px));
      fmt_hits[csr_word[REG_FORMAT][2:0]]++;
      pixels_sent++;
   endtask

   // stop sending and let every pending pixel come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [7:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      csr_word[idx] = val;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [7:0] fmt_word, input logic [7:0] r,
                               input logic [7:0] g, input logic [7:0] b, input logic all);
      drain();
      if (all || csr_word[REG_FORMAT] != fmt_word) write_csr(REG_FORMAT, fmt_word);
      if (all || csr_word[REG_BG_RED] != r) write_csr(REG_BG_RED, r);
      if (all || csr_word[REG_BG_GRN] != g) write_csr(REG_BG_GRN, g);
      if (all || csr_word[REG_BG_BLU] != b) write_csr(REG_BG_BLU, b);
      csr_we <= 1'b0;
      settings++;
   endtask

   initial begin : rsp_sink
      int   stall;
      rgb_t got, want;
      while (reset) @(posedge clock);
      forever begin
         stall = (rsp_stall_max > 0) ? $urandom_range(0, rsp_stall_max) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got = '{rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16]};
         if (pending_pixels.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: pixel %06h with none expected", $time, rsp_tdata);
         end else begin
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (got.red !== want.red) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: red expected %02h got %02h", $time, want.red, got.red);
            end
            if (got.green !== want.green) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: green expected %02h got %02h", $time, want.green, got.green);
            end
            if (got.blue !== want.blue) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: blue expected %02h got %02h", $time, want.blue, got.blue);
            end
         end
      end
   end

   initial begin : stimulus
      int         n, ph, sel;
      dir_row_t   row;
      logic [7:0] fw, r, g, b;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < $size(DIRECTED); n++) begin
         row = DIRECTED[n];
         if (csr_word[REG_FORMAT] != row.fmt_word || csr_word[REG_BG_RED] != row.bg_r ||
             csr_word[REG_BG_GRN] != row.bg_g || csr_word[REG_BG_BLU] != row.bg_b)
            program_regs(row.fmt_word, row.bg_r, row.bg_g, row.bg_b, 1'b0);
         send_pixel({row.s4, row.s3, row.s2, row.s1}, row.typed, row.want);
      end

      for (ph = 0; ph < PHASES; ph++) begin
         sel = $urandom_range(0, 15);
         fw = (sel < 14) ? 8'(sel % 5) : 8'($urandom_range(5, 7));
         if ($urandom_range(0, 3) == 0) fw[7:3] = 5'($urandom);
         r = pick_background();
         g = pick_background();
         b = pick_background();
         // background extremes, and one phase with no idling on either side
         if (ph == 0) begin
            fw = {5'd0, FMT_RGBA};
            {r, g, b} = '0;
         end else if (ph == 1) begin
            fw = {5'd0, FMT_GREYA};
            {r, g, b} = '1;
         end
         program_regs(fw, r, g, b, 1'b1);
         req_gap_max = ($urandom_range(0, 2) == 0 || ph == 2) ? 0 : 3;
         rsp_stall_max = ($urandom_range(0, 2) == 0 || ph == 2) ? 0 : 3;
         for (n = 0; n < PIXELS_PER_PHASE; n++)
            send_pixel({pick_sample(), pick_sample(), pick_sample(), pick_sample()}, 1'b0,
                       '{8'd0, 8'd0, 8'd0});
      end

      drain();
      repeat (8) @(posedge clock);
      if (pending_pixels.size() != 0) begin
         errors++;
         $display("%0t: %0d expected pixels never came out", $time, pending_pixels.size());
      end
      $display("Sent %0d pixels (%0d from the table) under %0d register settings, %0d checked.",
               pixels_sent, $size(DIRECTED), settings, pixels_checked);
      $display("Pixels per format code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d", fmt_hits[0],
               fmt_hits[1], fmt_hits[2], fmt_hits[3], fmt_hits[4], fmt_hits[5], fmt_hits[6],
               fmt_hits[7]);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ pixel_to_rgb8_with_background_top.f @@
sv/p2rgb_pkg.sv
sv/p2rgb_unpack.sv
sv/p2rgb_mix.sv
sv/p2rgb_div.sv
sv/pixel_to_rgb8_with_background_top.sv
bench/pixel_to_rgb8_with_background_top_test.sv
